/* sv/b64e_pkg.sv */
// ============================================================================
// b64e_pkg - shared types and helpers for the base64 encoder
// Group entry passed from the byte packer to the character emitter, and
// the sextet-to-character mapping of the standard alphabet.
// ============================================================================
package b64e_pkg;

    localparam logic [6:0] PAD_CHAR    = 7'h3D;  // '='
    localparam logic [5:0] SEXTET_MASK = 6'h3F;

    // One packed group of up to three bytes, first byte in the top bits
    typedef struct packed {
        logic [23:0] bits;
        logic [1:0]  nbytes;  // 1..3 valid bytes
        logic        eom;     // group closes the message
    } grp_t;

    // Standard alphabet: A-Z, a-z, 0-9, '+', '/'
    function automatic logic [6:0] sextet_char(input logic [5:0] v);
        logic [6:0] c;
        begin
            c = 7'h2F;  // '/'
            if (v < 6'd26) begin
                c = 7'h41 + {1'b0, v};
            end
            else if (v < 6'd52) begin
                c = 7'h61 + {1'b0, v} - 7'd26;
            end
            else if (v < 6'd62) begin
                c = 7'h30 + {1'b0, v} - 7'd52;
            end
            else if (v == 6'd62) begin
                c = 7'h2B;  // '+'
            end
            return c;
        end
    endfunction

endpackage

/* sv/b64e_front.sv */
// ============================================================================
// b64e_front - byte packer
// Gathers input bytes into groups of three and pushes a group entry when a
// group completes or the message ends; partial groups stay pending here.
// ============================================================================
module b64e_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [7:0]       in_byte,
    input  logic             in_last,
    output logic             push,
    output b64e_pkg::grp_t   push_grp,
    input  logic             q_full
);
    import b64e_pkg::*;

    logic [15:0] bytes_reg;
    logic [15:0] bytes_next;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;
    logic        accept;
    logic [23:0] grp_bits;
    logic [1:0]  nbytes;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    // merge the new byte with the pending ones
    always_comb
    begin
        unique case (count_reg)
            2'd1:
            begin
                grp_bits = {bytes_reg[15:8], in_byte, 8'h00};
                nbytes   = 2'd2;
            end
            2'd2:
            begin
                grp_bits = {bytes_reg, in_byte};
                nbytes   = 2'd3;
            end
            default:
            begin
                grp_bits = {in_byte, 16'h0000};
                nbytes   = 2'd1;
            end
        endcase
    end

    assign push            = accept && (nbytes == 2'd3 || in_last);
    assign push_grp.bits   = grp_bits;
    assign push_grp.nbytes = nbytes;
    assign push_grp.eom    = in_last;

    // pending state update
    always_comb
    begin
        bytes_next = bytes_reg;
        count_next = count_reg;
        if (push) begin
            bytes_next = 16'h0000;
            count_next = 2'd0;
        end
        else if (accept) begin
            bytes_next = grp_bits[23:8];
            count_next = nbytes;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            bytes_reg <= 16'h0000;
            count_reg <= 2'd0;
        end
        else begin
            bytes_reg <= bytes_next;
            count_reg <= count_next;
        end
    end

endmodule

/* sv/b64e_queue.sv */
// ============================================================================
// b64e_queue - two-entry group queue
// Decouples the byte packer from the character emitter.
// ============================================================================
module b64e_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  b64e_pkg::grp_t   push_grp,
    output logic             full,
    input  logic             pop,
    output logic             q_valid,
    output b64e_pkg::grp_t   q_grp
);
    import b64e_pkg::*;

    grp_t        mem [2];
    logic        wr_ptr_reg;
    logic        wr_ptr_next;
    logic        rd_ptr_reg;
    logic        rd_ptr_next;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;

    assign full    = (count_reg == 2'd2);
    assign q_valid = (count_reg != 2'd0);
    assign q_grp   = mem[rd_ptr_reg];

    // storage
    always_ff @(posedge clk)
    begin
        if (push) begin
            mem[wr_ptr_reg] <= push_grp;
        end
    end

    // pointers and fill count
    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* sv/b64e_back.sv */
// ============================================================================
// b64e_back - character emitter
// Turns the head group into four characters, one per cycle unless out_ready
// stalls, with '=' pad for short groups; drives a registered output beat.
// ============================================================================
module b64e_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_valid,
    input  b64e_pkg::grp_t   q_grp,
    output logic             pop,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [6:0]       out_char,
    output logic             out_last
);
    import b64e_pkg::*;

    logic        valid_reg;
    logic        valid_next;
    logic [6:0]  char_reg;
    logic [6:0]  char_next;
    logic        last_reg;
    logic        last_next;
    logic [1:0]  idx_reg;
    logic [1:0]  idx_next;
    logic        load;
    logic [4:0]  shift;
    logic [5:0]  sextet;

    assign load  = q_valid && (!valid_reg || out_ready);
    assign pop   = load && (idx_reg == 2'd3);

    // select the sextet for the current character slot
    assign shift  = 5'd18 - 5'd6 * {3'b000, idx_reg};
    assign sextet = 6'(q_grp.bits >> shift) & SEXTET_MASK;

    always_comb
    begin
        valid_next = valid_reg;
        char_next  = char_reg;
        last_next  = last_reg;
        idx_next   = idx_reg;
        if (load) begin
            valid_next = 1'b1;
            char_next  = (idx_reg <= q_grp.nbytes) ? sextet_char(sextet) : PAD_CHAR;
            last_next  = (idx_reg == 2'd3) && q_grp.eom;
            idx_next   = idx_reg + 2'd1;
        end
        else if (out_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end
        else begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        char_reg <= char_next;
        last_reg <= last_next;
    end

    assign out_valid = valid_reg;
    assign out_char  = char_reg;
    assign out_last  = last_reg;

endmodule

/* sv/base64_encoder_unit.sv */
// A group closed by an accepted byte is written into the group queue; the emitter
// then registers its first character into the output register behind m_axis_tvalid.
// Throughput: one character per cycle from the emitter while the output is not stalled,
// four per group; a two-entry group queue absorbs bursts.
// Reset: rst_n asynchronous, active low; clears pending bytes, queue and output.
// Partial groups produce nothing until the byte marked last arrives.
// ============================================================================
// base64_encoder_unit - streaming base64 encoder, standard alphabet
// Byte packer, group queue and character emitter; '=' pads short final groups.
// ============================================================================
module base64_encoder_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,   // end_of_message
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [6:0] out_char, [7] zero
    output logic        m_axis_tlast    // final_char
);
    import b64e_pkg::*;

    logic        push;
    grp_t        push_grp;
    logic        q_full;
    logic        pop;
    logic        q_valid;
    grp_t        q_grp;
    logic [6:0]  out_char;

    b64e_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_byte  (s_axis_tdata),
        .in_last  (s_axis_tlast),
        .push     (push),
        .push_grp (push_grp),
        .q_full   (q_full)
    );

    b64e_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_grp (push_grp),
        .full     (q_full),
        .pop      (pop),
        .q_valid  (q_valid),
        .q_grp    (q_grp)
    );

    b64e_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_grp     (q_grp),
        .pop       (pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_char  (out_char),
        .out_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {1'b0, out_char};

endmodule
